// File: hdl/ljes_pkg.sv
// Package: shared types and constants for the Lennard-Jones energy sum block.
`default_nettype none
package ljes_pkg;

  localparam int unsigned AddrBits = 3;

  // register byte addresses
  localparam logic [AddrBits-1:0] RegAtomCount    = 3'd0;
  localparam logic [AddrBits-1:0] RegEnergyWeight = 3'd4;

  // pair kinds
  localparam logic [1:0] KindVdw    = 2'd0;
  localparam logic [1:0] KindHbond  = 2'd1;
  localparam logic [1:0] KindSpring = 2'd2;
  localparam logic [1:0] KindUndef  = 2'd3;

  localparam logic [15:0] AtomCountReset    = 16'd1;
  localparam logic [15:0] EnergyWeightReset = 16'd13107;

  // input word
  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic [15:0]        target_distance;
    logic [1:0]         pair_kind;
    logic               is_last;
  } pair_t;

  // result word
  typedef struct packed {
    logic signed [31:0] pair_energy;
    logic signed [31:0] mean_score;
    logic               last_out;
  } result_t;

  // word passed from front end to back end
  typedef struct packed {
    logic        active;   // kind 0/1 and weight nonzero
    logic        zero_d;   // distance zero
    logic [63:0] d2;
    logic [15:0] tdist;
    logic        is_last;
  } job_t;

endpackage
`default_nettype wire

// File: hdl/ljes_if.sv
// Interface: valid/ready channel carrying one payload word.
`default_nettype none
interface ljes_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/pair_lennard_jones_energy_sum.sv
// Top level: APB registers, front end, queue and back end.
// In the front end each pair is accepted, its three squares are summed on
// one 32x32 multiplier and the job is handed off. The back end goes straight
// to accumulation for a pair of kind 2 or 3, zero weight or zero distance,
// skips the power steps after the bit-serial 64-step ratio division when the
// distance ratio saturates, and otherwise runs a full evaluation; a last pair
// with a nonzero atom count adds the 48-step mean division. The two ends
// overlap through a two-entry queue; the result register holds a word until
// it is taken, and the back end waits while it does.
`default_nettype none
module pair_lennard_jones_energy_sum #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  ljes_if.sink             pair_in,
  ljes_if.source           result_out
);
  import ljes_pkg::*;

  logic [15:0] atom_count_q, weight_q;
  job_t fe_job, q_job;
  logic fe_valid, fe_ready, q_valid, q_ready;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_count_q <= AtomCountReset;
      weight_q     <= EnergyWeightReset;
    end else if (psel && penable && pwrite) begin
      if (paddr == RegAtomCount) atom_count_q <= pwdata[15:0];
      if (paddr == RegEnergyWeight) weight_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == RegAtomCount) prdata = {16'd0, atom_count_q};
    else if (paddr == RegEnergyWeight) prdata = {16'd0, weight_q};
  end

  ljes_front #(.CoordBits(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .weight_i(weight_q),
    .in_valid_i(pair_in.valid), .in_ready_o(pair_in.ready),
    .in_data_i(pair_in.data),
    .job_valid_o(fe_valid), .job_ready_i(fe_ready), .job_o(fe_job)
  );

  ljes_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fe_valid), .wr_ready_o(fe_ready), .wr_data_i(fe_job),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_job)
  );

  ljes_back u_back (
    .clk_i, .rst_ni, .weight_i(weight_q), .atom_count_i(atom_count_q),
    .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .res_valid_o(result_out.valid), .res_ready_i(result_out.ready),
    .res_o(result_out.data)
  );
endmodule
`default_nettype wire

// File: hdl/ljes_front.sv
// Front end: accepts a pair, classifies it and computes the squared distance.
`default_nettype none
module ljes_front #(
  parameter int unsigned CoordBits = 24
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [15:0]     weight_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ljes_pkg::pair_t in_data_i,
  output logic                 job_valid_o,
  input  wire logic            job_ready_i,
  output ljes_pkg::job_t       job_o
);
  import ljes_pkg::*;

  typedef enum logic [2:0] {
    FeIdle = 3'b001,
    FeSq   = 3'b010,
    FeOut  = 3'b100
  } fe_state_e;

  fe_state_e state_q, state_d;
  logic [31:0] ax_q [3];
  logic [63:0] d2_q, d2_d;
  logic [1:0]  ax_idx_q, ax_idx_d;
  logic        active_q, active_d, last_q, last_d;
  logic [15:0] t_q, t_d;
  logic [31:0] ax_d [3];

  // per-axis magnitude, clamped to 2^31
  function automatic logic [31:0] axis_mag(logic [31:0] a, logic [31:0] b);
    logic signed [CoordBits:0] sa, sb, df;
    logic [CoordBits:0] m;
    logic [32:0] mx;
    begin
      sa = {a[CoordBits-1], a[CoordBits-1:0]};
      sb = {b[CoordBits-1], b[CoordBits-1:0]};
      df = sa - sb;
      m  = df[CoordBits] ? (~df + 1'b1) : df;
      mx = 33'(m);
      axis_mag = (mx > 33'h080000000) ? 32'h80000000 : mx[31:0];
    end
  endfunction

  always_comb begin
    ax_d[0] = axis_mag(in_data_i.pos_a_x, in_data_i.pos_b_x);
    ax_d[1] = axis_mag(in_data_i.pos_a_y, in_data_i.pos_b_y);
    ax_d[2] = axis_mag(in_data_i.pos_a_z, in_data_i.pos_b_z);
  end

  logic [31:0] sq_op;
  logic [63:0] sq_prod;
  assign sq_op   = ax_q[ax_idx_q];
  assign sq_prod = sq_op * sq_op;

  always_comb begin
    state_d  = state_q;
    d2_d     = d2_q;
    ax_idx_d = ax_idx_q;
    active_d = active_q;
    last_d   = last_q;
    t_d      = t_q;
    in_ready_o = 1'b0;
    job_valid_o = 1'b0;
    unique case (state_q)
      FeIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          d2_d     = '0;
          ax_idx_d = '0;
          active_d = ((in_data_i.pair_kind == KindVdw) ||
                      (in_data_i.pair_kind == KindHbond)) && (weight_i != '0);
          last_d   = in_data_i.is_last;
          t_d      = in_data_i.target_distance;
          state_d  = FeSq;
        end
      end
      FeSq: begin
        // one 32x32 square per cycle
        d2_d = d2_q + sq_prod;
        if (ax_idx_q == 2'd2) state_d = FeOut;
        else ax_idx_d = ax_idx_q + 2'd1;
      end
      FeOut: begin
        job_valid_o = 1'b1;
        if (job_ready_i) state_d = FeIdle;
      end
      default: state_d = FeIdle;
    endcase
  end

  assign job_o = '{active: active_q, zero_d: (d2_q == '0), d2: d2_q,
                   tdist: t_q, is_last: last_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q     <= d2_d;
    ax_idx_q <= ax_idx_d;
    active_q <= active_d;
    last_q   <= last_d;
    t_q      <= t_d;
    if (state_q == FeIdle && in_valid_i) begin
      ax_q[0] <= ax_d[0];
      ax_q[1] <= ax_d[1];
      ax_q[2] <= ax_d[2];
    end
  end
endmodule
`default_nettype wire

// File: hdl/ljes_fifo.sv
// Queue: two-entry word buffer between front end and back end.
`default_nettype none
module ljes_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  wire ljes_pkg::job_t wr_data_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output ljes_pkg::job_t      rd_data_o
);
  import ljes_pkg::*;

  job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

// File: hdl/ljes_back.sv
// Back end: ratio division, powers, weighting, accumulation and mean.
`default_nettype none
module ljes_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [15:0]      weight_i,
  input  wire logic [15:0]      atom_count_i,
  input  wire logic             job_valid_i,
  output logic                  job_ready_o,
  input  wire ljes_pkg::job_t   job_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output ljes_pkg::result_t     res_o
);
  import ljes_pkg::*;

  typedef enum logic [9:0] {
    BkIdle = 10'b0000000001,
    BkDiv  = 10'b0000000010,
    BkQ2   = 10'b0000000100,
    BkQ3   = 10'b0000001000,
    BkQ6   = 10'b0000010000,
    BkWt   = 10'b0000100000,
    BkAcc  = 10'b0001000000,
    BkMean = 10'b0010000000,
    BkFix  = 10'b0100000000,
    BkOut  = 10'b1000000000
  } bk_state_e;

  localparam logic signed [47:0] SumMax = 48'sh7FFFFFFFFFFF;
  localparam logic signed [47:0] SumMin = -48'sh800000000000;

  bk_state_e state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] dvd_q, dvd_d;     // dividend shifted out MSB first, quotient in
  logic [63:0] dvs_q, dvs_d;
  logic [63:0] q_q, q_d, q3_q, q3_d, q6_q, q6_d;
  logic        neg_q, neg_d, last_q, last_d;
  logic signed [31:0] e_q, e_d, mean_q, mean_d;
  logic signed [47:0] sum_q, sum_d;
  logic [47:0] mag_q, mag_d;     // mean division: magnitude / count
  logic [15:0] mrem_q, mrem_d;
  logic        mneg_q, mneg_d;
  logic [35:0] pa;
  logic [29:0] pb;
  logic [63:0] pr;
  logic [64:0] trial;
  logic [16:0] mtrial;
  logic [63:0] diff;
  logic signed [48:0] s_ext;

  // (x*x + 2^23) >> 24 for x < 2^42, via 21-bit halves
  function automatic logic [63:0] sq_q24(logic [41:0] x);
    logic [20:0] lo, hi;
    logic [41:0] hh, hl, ll;
    logic [84:0] f;
    begin
      lo = x[20:0]; hi = x[41:21];
      hh = hi * hi; hl = hi * lo; ll = lo * lo;
      f = {1'b0, hh, 42'd0} + {21'd0, hl, 22'd0} + {43'd0, ll} + 85'd8388608;
      sq_q24 = {3'd0, f[84:24]};
    end
  endfunction

  // (x*w + 2^23) >> 24, x below 2^60, w 16 bits, two 30x16 products
  function automatic logic [63:0] wt_q24(logic [59:0] x, logic [15:0] w);
    logic [45:0] lo_p, hi_p;
    logic [75:0] f;
    begin
      lo_p = x[29:0] * w;
      hi_p = x[59:30] * w;
      f = {hi_p, 30'd0} + {30'd0, lo_p} + 76'd8388608;
      wt_q24 = {12'd0, f[75:24]};
    end
  endfunction

  // Q24 rounded product, a below 2^36 and b below 2^30, as two 18x30 products
  always_comb begin
    logic [47:0] p_hi, p_lo;
    logic [66:0] full;
    p_hi = pa[35:18] * pb;
    p_lo = pa[17:0] * pb;
    full = {1'b0, p_hi, 18'd0} + {19'd0, p_lo} + 67'd8388608;
    pr   = {21'd0, full[66:24]};
  end

  assign trial  = {rem_q[63:0], dvd_q[63]} - {1'b0, dvs_q};
  assign mtrial = {mrem_q, mag_q[47]} - {1'b0, atom_count_i};
  assign diff   = (q6_q >= {q3_q[62:0], 1'b0}) ? q6_q - {q3_q[62:0], 1'b0}
                                               : {q3_q[62:0], 1'b0} - q6_q;
  assign s_ext  = 49'(sum_q) + 49'(e_q);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; rem_d = rem_q; dvd_d = dvd_q;
    dvs_d = dvs_q; q_d = q_q; q3_d = q3_q; q6_d = q6_q;
    neg_d = neg_q; last_d = last_q; e_d = e_q; mean_d = mean_q;
    sum_d = sum_q; mag_d = mag_q; mrem_d = mrem_q; mneg_d = mneg_q;
    pa = '0; pb = '0;
    job_ready_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      BkIdle: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          last_d = job_i.is_last;
          dvd_d  = {8'd0, 32'(job_i.tdist) * 32'(job_i.tdist), 24'd0};
          dvs_d  = job_i.d2;
          rem_d  = '0;
          cnt_d  = '0;
          e_d    = '0;
          if (!job_i.active) state_d = BkAcc;
          else if (job_i.zero_d) begin
            e_d = 32'sh7FFFFFFF;
            state_d = BkAcc;
          end else state_d = BkDiv;
        end
      end
      BkDiv: begin
        // restoring division, one quotient bit per cycle
        if (!trial[64]) rem_d = trial;
        else rem_d = {rem_q[63:0], dvd_q[63]};
        dvd_d = {dvd_q[62:0], !trial[64]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) state_d = BkQ2;
      end
      BkQ2: begin
        q_d = dvd_q;
        if (dvd_q >= 64'h40000000) begin
          e_d = 32'sh7FFFFFFF;
          state_d = BkAcc;
        end else begin
          pa = dvd_q[35:0]; pb = dvd_q[29:0];
          q3_d = pr;   // q2
          state_d = BkQ3;
        end
      end
      BkQ3: begin
        pa = q3_q[35:0]; pb = q_q[29:0];
        q3_d = pr;
        state_d = BkQ6;
      end
      BkQ6: begin
        // q3 < 2^42: product may exceed 64 bits, split in halves
        q6_d = sq_q24(q3_q[41:0]);
        state_d = BkWt;
      end
      BkWt: begin
        neg_d = (q6_q < {q3_q[62:0], 1'b0});
        q_d   = wt_q24(diff[59:0], weight_i);
        state_d = BkFix;
      end
      BkFix: begin
        if (!neg_q) e_d = (q_q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q_q[31:0];
        else e_d = (q_q > 64'h80000000) ? -32'sh80000000 : -(q_q[31:0]);
        state_d = BkAcc;
      end
      BkAcc: begin
        if (s_ext > 49'(SumMax)) sum_d = SumMax;
        else if (s_ext < 49'(SumMin)) sum_d = SumMin;
        else sum_d = s_ext[47:0];
        mean_d = '0;
        if (last_q && atom_count_i != '0) begin
          mneg_d = sum_d[47];
          mag_d  = sum_d[47] ? 48'(-sum_d) : 48'(sum_d);
          mrem_d = '0;
          cnt_d  = '0;
          state_d = BkMean;
        end else state_d = BkOut;
      end
      BkMean: begin
        if (!mtrial[16]) mrem_d = mtrial[15:0];
        else mrem_d = {mrem_q[14:0], mag_q[47]};
        mag_d = {mag_q[46:0], !mtrial[16]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd47) begin
          state_d = BkOut;
          if (!mneg_q) mean_d = (mag_d > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : mag_d[31:0];
          else mean_d = (mag_d > 48'h80000000) ? -32'sh80000000 : -(mag_d[31:0]);
        end
      end
      BkOut: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (last_q) sum_d = '0;
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  assign res_o = '{pair_energy: e_q, mean_score: mean_q, last_out: last_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d; rem_q <= rem_d; dvd_q <= dvd_d; dvs_q <= dvs_d;
    q_q <= q_d; q3_q <= q3_d; q6_q <= q6_d; neg_q <= neg_d;
    last_q <= last_d; e_q <= e_d; mean_q <= mean_d; mag_q <= mag_d;
    mrem_q <= mrem_d; mneg_q <= mneg_d;
  end
endmodule
`default_nettype wire
